FILE: rtl/timed_event_script_sequencer_core_assert.svh
// Assertion macros shared by the sequencer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TIMED_EVENT_SCRIPT_SEQUENCER_CORE_ASSERT_SVH
`define TIMED_EVENT_SCRIPT_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define TESS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define TESS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TESS_ASSERT(label, clk, rst, prop, msg)
`define TESS_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

FILE: rtl/tess_pkg.sv
// Package for the timed event script sequencer: beat types, codes, defaults.
// No dependencies; imported by every sequencer module.
package tess_pkg;

   // default sizing
   localparam int DEF_MAX_EVENTS     = 64;
   localparam int DEF_NUM_CONDITIONS = 8;

   // widths fixed by the beat fields and register map
   localparam int LEN_W        = 7;
   localparam int POS_OUT_W    = 7;
   localparam int STORE_ADDR_W = 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // request op codes
   localparam logic [1:0] OP_EVAL    = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_LOAD    = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // event word kinds
   localparam logic [2:0] KIND_TIMED      = 3'd0;
   localparam logic [2:0] KIND_WAIT       = 3'd1;
   localparam logic [2:0] KIND_JUMP       = 3'd2;
   localparam logic [2:0] KIND_CJUMP      = 3'd3;
   localparam logic [2:0] KIND_TRANSITION = 3'd4;

   // register indexes
   localparam logic REG_PROGRAM_LENGTH = 1'b0;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  condition_bits;
      logic [5:0]  word_index;
      logic [2:0]  word_kind;
      logic [31:0] word_interval;
      logic [2:0]  word_condition;
      logic [3:0]  word_action;
      logic [3:0]  word_message;
      logic [7:0]  word_target_a;
      logic [7:0]  word_target_b;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] action_id;
      logic [3:0] message_id;
      logic [6:0] position;
      logic       finished;
   } rsp_type;

   // one program store entry, 62 bits
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] interval;
      logic [2:0]  condition;
      logic [3:0]  action;
      logic [3:0]  message;
      logic [7:0]  target_a;
      logic [7:0]  target_b;
   } prog_word_type;

   // store write request
   typedef struct packed {
      logic                    en;
      logic [STORE_ADDR_W-1:0] addr;
      prog_word_type           data;
   } store_wr_type;

endpackage

FILE: rtl/timed_event_script_sequencer_core.sv
// Timed event script sequencer, top level: beat registers, CSR port, store, exec.
// Depends on tess_pkg, tess_store and tess_exec.
//
// Takes one request beat per clock and returns one response beat per request, in
// order, through two registers (one input register, one result register).
// Every op (evaluate, tick, load, restart) finishes in that single pass; the only
// thing that limits rate is the single read port of the program store, which is
// pre-read at the position the next beat will see, so back-to-back evaluates never
// wait. A stalled response blocks new beats only once both registers are full.
// The store has no reset and needs no clearing pass; evaluating a slot inside the
// program length that was never loaded gives undefined fields. program_length is
// the only register (byte address 0) and should be written while the block is idle.
module timed_event_script_sequencer_core
   import tess_pkg::*;
#(
   parameter int MAX_EVENTS     = DEF_MAX_EVENTS,
   parameter int NUM_CONDITIONS = DEF_NUM_CONDITIONS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // CSR port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(MAX_EVENTS);

   logic             in_valid_ff;
   req_type          in_item_ff;
   logic             out_valid_ff;
   rsp_type          out_data_ff;
   logic [LEN_W-1:0] length_ff;

   logic             advance;
   logic             step_en;
   rsp_type          result;
   store_wr_type     store_wr;
   logic [AW-1:0]    rd_addr;
   prog_word_type    word;

   // pipeline flow
   assign advance   = !out_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_data_ff <= result;
      end
   end

   // CSR: program_length
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_PROGRAM_LENGTH)) begin
         length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PROGRAM_LENGTH) begin
         csr_prdata = CSR_DATA_W'(length_ff);
      end
   end

   tess_store #(
      .DEPTH (MAX_EVENTS),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .wr         (store_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (word)
   );

   tess_exec #(
      .MAX_EVENTS     (MAX_EVENTS),
      .NUM_CONDITIONS (NUM_CONDITIONS),
      .AW             (AW)
   ) u_exec (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .item           (in_item_ff),
      .word           (word),
      .program_length (length_ff),
      .result         (result),
      .store_wr       (store_wr),
      .rd_addr        (rd_addr)
   );

endmodule

FILE: rtl/tess_store.sv
// Program store: one write port, one registered read port, write-first bypass.
// Depends on tess_pkg.
module tess_store
   import tess_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_EVENTS,
   parameter int AW    = $clog2(DEF_MAX_EVENTS)
) (
   input  logic          clock,
   input  store_wr_type  wr,
   input  logic [AW-1:0] rd_addr,
   output prog_word_type rd_data_ff
);

   prog_word_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // registered read; a same-cycle write to the read slot is forwarded
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr[AW-1:0] == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/tess_exec.sv
// Execution stage: position and timer state, per-beat word evaluation.
// Depends on tess_pkg and the assertion macro header.
`include "timed_event_script_sequencer_core_assert.svh"

module tess_exec
   import tess_pkg::*;
#(
   parameter int MAX_EVENTS     = DEF_MAX_EVENTS,
   parameter int NUM_CONDITIONS = DEF_NUM_CONDITIONS,
   parameter int AW             = $clog2(DEF_MAX_EVENTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  req_type          item,
   input  prog_word_type    word,
   input  logic [LEN_W-1:0] program_length,
   output rsp_type          result,
   output store_wr_type     store_wr,
   output logic [AW-1:0]    rd_addr
);

   localparam int PW = $clog2(MAX_EVENTS + 1);
   localparam int LW = (PW > LEN_W) ? PW : LEN_W;

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   elapsed_ff, elapsed_in;

   logic [LW-1:0] len_ext, alen;
   logic          in_range;
   logic          cond_hi;
   logic          tgt_a_ok, tgt_b_ok;
   logic          fired;
   logic [3:0]    act, msg;

   // effective length, clamped to the store depth
   assign len_ext  = LW'(program_length);
   assign alen     = (len_ext > LW'(MAX_EVENTS)) ? LW'(MAX_EVENTS) : len_ext;
   assign in_range = LW'(pos_ff) < alen;

   // condition select; numbers past the condition count read low
   assign cond_hi = (32'(word.condition) < NUM_CONDITIONS) &&
                    item.condition_bits[word.condition];

   // one-based targets must land inside the program
   assign tgt_a_ok = (word.target_a != 8'd0) && ({1'b0, word.target_a} <= 9'(alen));
   assign tgt_b_ok = (word.target_b != 8'd0) && ({1'b0, word.target_b} <= 9'(alen));

   // next state and result
   always_comb begin
      pos_in        = pos_ff;
      elapsed_in    = elapsed_ff;
      fired         = 1'b0;
      act           = 4'd0;
      msg           = 4'd0;
      store_wr.en   = 1'b0;
      store_wr.addr = STORE_ADDR_W'(item.word_index);
      store_wr.data = '{kind:      item.word_kind,
                        interval:  item.word_interval,
                        condition: item.word_condition,
                        action:    item.word_action,
                        message:   item.word_message,
                        target_a:  item.word_target_a,
                        target_b:  item.word_target_b};
      if (step_en) begin
         case (item.op)
            OP_EVAL: begin
               if (in_range) begin
                  case (word.kind)
                     KIND_TIMED: begin
                        if (elapsed_ff >= word.interval) begin
                           elapsed_in = 32'd0;
                           fired      = 1'b1;
                           act        = word.action;
                           msg        = word.message;
                           pos_in     = pos_ff + PW'(1);
                        end
                     end
                     KIND_WAIT: begin
                        if (cond_hi) begin
                           pos_in = pos_ff + PW'(1);
                        end
                     end
                     KIND_JUMP: begin
                        if (tgt_a_ok) begin
                           pos_in     = PW'(word.target_a - 8'd1);
                           elapsed_in = 32'd0;
                        end
                     end
                     KIND_CJUMP: begin
                        if (cond_hi && tgt_b_ok) begin
                           pos_in     = PW'(word.target_b - 8'd1);
                           elapsed_in = 32'd0;
                        end else if (!cond_hi && tgt_a_ok) begin
                           pos_in     = PW'(word.target_a - 8'd1);
                           elapsed_in = 32'd0;
                        end
                     end
                     KIND_TRANSITION: begin
                        if (cond_hi && tgt_a_ok) begin
                           pos_in     = PW'(word.target_a - 8'd1);
                           elapsed_in = 32'd0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_TICK: begin
               if (elapsed_ff != 32'hFFFF_FFFF) begin
                  elapsed_in = elapsed_ff + 32'd1;
               end
            end
            OP_LOAD: begin
               store_wr.en = 32'(item.word_index) < MAX_EVENTS;
            end
            OP_RESTART: begin
               pos_in     = '0;
               elapsed_in = 32'd0;
            end
            default: begin
            end
         endcase
      end
   end

   assign result.fired      = fired;
   assign result.action_id  = act;
   assign result.message_id = msg;
   assign result.position   = POS_OUT_W'(pos_in);
   assign result.finished   = LW'(pos_in) >= alen;

   // read the word for the position the next beat will see
   assign rd_addr = (32'(pos_in) < MAX_EVENTS) ? pos_in[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         elapsed_ff <= 32'd0;
      end else begin
         pos_ff     <= pos_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // checks
   `TESS_ASSERT(a_fire_only_on_eval, clock, reset, result.fired |-> (step_en && item.op == OP_EVAL), "fire outside an evaluate beat")
   `TESS_ASSERT(a_fire_clears_timer, clock, reset, (step_en && result.fired) |=> (elapsed_ff == 32'd0), "timer not cleared after fire")
   `TESS_ASSERT(a_tick_holds_pos, clock, reset, (step_en && item.op == OP_TICK) |=> $stable(pos_ff), "tick moved the position")
   `TESS_ASSERT(a_tick_no_decrease, clock, reset, (step_en && item.op == OP_TICK) |=> (elapsed_ff >= $past(elapsed_ff)), "tick lowered the timer")
   `TESS_ASSERT_NEVER(a_pos_bound, clock, reset, 32'(pos_ff) > MAX_EVENTS, "position past store depth")

endmodule
